@@ hdl/smf_pkg.sv @@
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the sliding median filter
// Holds the sequencer states, the shared unit's operation codes and flag
// group, and the fixed width and reset value of the length register.
// ----------------------------------------------------------------------------
`default_nettype none

package smf_pkg;

   // The length register is four bits wide and resets to eight entries.
   localparam int LEN_W = 4;
   localparam logic [LEN_W-1:0] LEN_RESET = 4'd8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DIR,
      ST_MOVE,
      ST_PLACE,
      ST_MED0,
      ST_MED1,
      ST_MED2,
      ST_DONE
   } state_type;

   typedef enum logic {
      ALU_SUB,
      ALU_ADD
   } alu_op_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } alu_flags_type;

endpackage

`default_nettype wire

@@ hdl/smf_ram.sv @@
// ----------------------------------------------------------------------------
// smf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered, so a read
// of an address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module smf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/smf_alu.sv @@
// ----------------------------------------------------------------------------
// smf_alu: shared add / compare unit
// Subtracts to compare two samples, or adds two samples for the mean; the
// result is one bit wider than a sample, so neither operation overflows.
// ----------------------------------------------------------------------------
`default_nettype none

module smf_alu #(
   parameter int WIDTH = 16
) (
   input  wire smf_pkg::alu_op_type        op,
   input  wire logic signed [WIDTH-1:0]    a,
   input  wire logic signed [WIDTH-1:0]    b,
   output logic signed [WIDTH:0]           result,
   output smf_pkg::alu_flags_type          flags
);

   import smf_pkg::*;

   logic signed [WIDTH:0] a_ext;
   logic signed [WIDTH:0] b_ext;

   assign a_ext = {a[WIDTH-1], a};
   assign b_ext = {b[WIDTH-1], b};

   always_comb begin
      unique case (op)
         ALU_ADD: begin
            result = a_ext + b_ext;
         end
         ALU_SUB: begin
            result = a_ext - b_ext;
         end
         default: begin
            result = a_ext - b_ext;
         end
      endcase
   end

   // Flags are only meaningful for a subtraction.
   assign flags.lt = result[WIDTH];
   assign flags.eq = (result == '0);

endmodule

`default_nettype wire

@@ hdl/sliding_median_filter_top.sv @@
// ----------------------------------------------------------------------------
// sliding_median_filter_top: sliding window median filter
// Items are handled one at a time: a new item is taken only in the idle
//   state, after the previous result has been moved to the output register;
//   the scan and insertion run through a single compare unit and one port
//   pair of the sorted RAM.
// Reset (synchronous, active high): length 8, window empty, no result held.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_median_filter_top #(
   parameter int WINDOW_MAX   = 8,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_median,
   input  wire logic                           csr_wr_en,
   input  wire logic [smf_pkg::LEN_W-1:0]      csr_wr_data
);

   import smf_pkg::*;

   // The block keeps two stores of the window. The ring RAM holds the samples
   // in arrival order, so that the sample about to be overwritten can be
   // looked up. The sort RAM holds the same valid samples in ascending order.
   // Each new item replaces the evicted value in the sorted list: the old
   // value is located by a linear scan, then the new value is walked up or
   // down one position per cycle, shifting neighbours over it, until the
   // order is restored. While the window is still filling there is nothing
   // to evict and the new value simply enters at the top and walks down.
   // The median is then read straight from the middle of the sorted list.
   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);

   state_type                      state_ff, state_in;
   logic [LEN_W-1:0]               length_ff, length_in;
   logic [CNT_W-1:0]               fill_ff, fill_in;
   logic [PTR_W-1:0]               wp_ff, wp_in;
   logic [PTR_W-1:0]               pos_ff, pos_in;
   logic [PTR_W-1:0]               idx_ff, idx_in;
   logic                           dir_up_ff, dir_up_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_WIDTH-1:0] new_ff, new_in;
   logic signed [SAMPLE_WIDTH-1:0] old_ff, old_in;
   logic signed [SAMPLE_WIDTH-1:0] hi_ff, hi_in;
   logic signed [SAMPLE_WIDTH-1:0] res_ff, res_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_median_ff, rsp_median_in;

   logic [CNT_W-1:0]               eff_len;
   logic [PTR_W-1:0]               wp_wrap;
   logic [PTR_W-1:0]               nbr;
   logic [PTR_W-1:0]               mid;
   logic                           pos_up_ok, pos_dn_ok;
   logic                           nbr_up_ok, nbr_dn_ok;
   logic                           move_on;
   logic                           new_above;

   logic                           ring_we;
   logic signed [SAMPLE_WIDTH-1:0] ring_rd_data;
   logic                           sort_we;
   logic [PTR_W-1:0]               sort_wr_addr;
   logic signed [SAMPLE_WIDTH-1:0] sort_wr_data;
   logic [PTR_W-1:0]               sort_rd_addr;
   logic signed [SAMPLE_WIDTH-1:0] sort_rd_data;

   alu_op_type                     alu_op;
   logic signed [SAMPLE_WIDTH-1:0] alu_a, alu_b;
   logic signed [SAMPLE_WIDTH:0]   alu_sum;
   alu_flags_type                  alu_flags;

   // Ring store in arrival order, read and written at the write pointer.
   smf_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (WINDOW_MAX)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_addr (wp_ff),
      .rd_data (ring_rd_data)
   );

   // Sorted copy of the valid entries, ascending from address zero.
   smf_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (WINDOW_MAX)
   ) u_sort_ram (
      .clock   (clock),
      .wr_en   (sort_we),
      .wr_addr (sort_wr_addr),
      .wr_data (sort_wr_data),
      .rd_addr (sort_rd_addr),
      .rd_data (sort_rd_data)
   );

   // The one arithmetic unit: compares during the scan and the walk, and
   // forms the two-sample sum for an even count.
   smf_alu #(
      .WIDTH (SAMPLE_WIDTH)
   ) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_sum),
      .flags  (alu_flags)
   );

   // A length of zero behaves as one, and a length above the window size
   // behaves as the window size.
   always_comb begin
      if (length_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (32'(length_ff) > 32'(WINDOW_MAX)) begin
         eff_len = CNT_W'(WINDOW_MAX);
      end else begin
         eff_len = CNT_W'(length_ff);
      end
   end

   assign wp_wrap   = ((CNT_W'(wp_ff) + CNT_W'(1)) >= eff_len) ? '0 : wp_ff + PTR_W'(1);
   assign nbr       = dir_up_ff ? pos_ff + PTR_W'(1) : pos_ff - PTR_W'(1);
   assign pos_up_ok = (CNT_W'(pos_ff) + CNT_W'(1)) < fill_ff;
   assign pos_dn_ok = (pos_ff != '0);
   assign nbr_up_ok = (CNT_W'(nbr) + CNT_W'(1)) < fill_ff;
   assign nbr_dn_ok = (nbr != '0);
   assign mid       = PTR_W'(fill_ff >> 1);

   // While walking, the new value keeps moving as long as the neighbour is
   // strictly on the wrong side of it.
   assign move_on   = dir_up_ff ? alu_flags.lt : (!alu_flags.lt && !alu_flags.eq);
   assign new_above = !alu_flags.lt && !alu_flags.eq;

   always_comb begin
      state_in      = state_ff;
      length_in     = length_ff;
      fill_in       = fill_ff;
      wp_in         = wp_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      dir_up_in     = dir_up_ff;
      rsp_valid_in  = rsp_valid_ff;
      new_in        = new_ff;
      old_in        = old_ff;
      hi_in         = hi_ff;
      res_in        = res_ff;
      rsp_median_in = rsp_median_ff;

      req_stall     = 1'b1;
      ring_we       = 1'b0;
      sort_we       = 1'b0;
      sort_wr_addr  = pos_ff;
      sort_wr_data  = new_ff;
      sort_rd_addr  = idx_ff;
      alu_op        = ALU_SUB;
      alu_a         = sort_rd_data;
      alu_b         = new_ff;

      // The result register is freed as soon as its item is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               // The ring write and the read of the evicted sample happen
               // together; the read returns the value before the write.
               new_in  = req_sample;
               ring_we = 1'b1;
               wp_in   = wp_wrap;
               if (fill_ff < eff_len) begin
                  fill_in   = fill_ff + CNT_W'(1);
                  pos_in    = PTR_W'(fill_ff);
                  dir_up_in = 1'b0;
                  if (fill_ff == '0) begin
                     state_in = ST_PLACE;
                  end else begin
                     sort_rd_addr = PTR_W'(fill_ff) - PTR_W'(1);
                     state_in     = ST_MOVE;
                  end
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            old_in       = ring_rd_data;
            idx_in       = '0;
            sort_rd_addr = '0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            alu_a = sort_rd_data;
            alu_b = old_ff;
            if (alu_flags.eq) begin
               pos_in   = idx_ff;
               state_in = ST_DIR;
            end else begin
               idx_in       = idx_ff + PTR_W'(1);
               sort_rd_addr = idx_ff + PTR_W'(1);
            end
         end
         ST_DIR: begin
            alu_a     = new_ff;
            alu_b     = old_ff;
            dir_up_in = new_above;
            if (alu_flags.eq) begin
               state_in = ST_PLACE;
            end else if (new_above && pos_up_ok) begin
               sort_rd_addr = pos_ff + PTR_W'(1);
               state_in     = ST_MOVE;
            end else if (!new_above && pos_dn_ok) begin
               sort_rd_addr = pos_ff - PTR_W'(1);
               state_in     = ST_MOVE;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_MOVE: begin
            alu_a = sort_rd_data;
            alu_b = new_ff;
            sort_we = 1'b1;
            if (move_on) begin
               // Shift the neighbour into the hole and follow it.
               sort_wr_data = sort_rd_data;
               pos_in       = nbr;
               if (dir_up_ff && nbr_up_ok) begin
                  sort_rd_addr = nbr + PTR_W'(1);
               end else if (!dir_up_ff && nbr_dn_ok) begin
                  sort_rd_addr = nbr - PTR_W'(1);
               end else begin
                  state_in = ST_PLACE;
               end
            end else begin
               state_in = ST_MED0;
            end
         end
         ST_PLACE: begin
            sort_we  = 1'b1;
            state_in = ST_MED0;
         end
         ST_MED0: begin
            sort_rd_addr = mid;
            state_in     = ST_MED1;
         end
         ST_MED1: begin
            hi_in = sort_rd_data;
            if (fill_ff[0]) begin
               res_in   = sort_rd_data;
               state_in = ST_DONE;
            end else begin
               sort_rd_addr = mid - PTR_W'(1);
               state_in     = ST_MED2;
            end
         end
         ST_MED2: begin
            // Mean of the two middle values, rounded towards minus infinity.
            alu_op   = ALU_ADD;
            alu_a    = hi_ff;
            alu_b    = sort_rd_data;
            res_in   = alu_sum[SAMPLE_WIDTH:1];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A length write restarts the window.
      if (csr_wr_en) begin
         length_in = csr_wr_data;
         fill_in   = '0;
         wp_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= LEN_RESET;
         fill_ff      <= '0;
         wp_ff        <= '0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         dir_up_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         fill_ff      <= fill_in;
         wp_ff        <= wp_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         dir_up_ff    <= dir_up_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff        <= new_in;
      old_ff        <= old_in;
      hi_ff         <= hi_in;
      res_ff        <= res_in;
      rsp_median_ff <= rsp_median_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

   // An accepted item always starts the sequencer, so the input is stalled
   // in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after an accepted item");

   // The fill count never exceeds the effective window length.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_len)
      else $error("fill count above window length");

   // The write pointer always lies inside the effective window.
   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(wp_ff) < eff_len)
      else $error("write pointer outside window");

   // A new result only appears from the hand-over state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the hand-over state");

endmodule

`default_nettype wire

@@ sim/median_check_pkg.sv @@
// ----------------------------------------------------------------------------
// median_check_pkg: expected-median tracking for the sliding median filter
// Keeps its own copy of the sample window and the length register, works
// out the median each accepted item should produce and checks results.
// ----------------------------------------------------------------------------
package median_check_pkg;

   class median_scoreboard;
      localparam int WIN_MAX = 8;

      logic signed [15:0] window [WIN_MAX];
      int unsigned        wr_ptr;
      int unsigned        fill;
      logic [3:0]         length_reg;
      logic signed [15:0] expected_medians [$];
      int unsigned        mismatches;

      function new();
         length_reg = smf_pkg::LEN_RESET;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         foreach (window[k]) window[k] = '0;
         wr_ptr = 0;
         fill   = 0;
      endfunction

      // Any write to the length register also empties the window.
      function void write_length(logic [3:0] value);
         length_reg = value;
         restart();
      endfunction

      function void note_sample(logic signed [15:0] sample);
         int unsigned        len;
         int unsigned        a;
         int unsigned        b;
         logic signed [15:0] sorted [WIN_MAX];
         logic signed [15:0] key;
         logic signed [16:0] sum;
         logic signed [15:0] median;

         if (length_reg == 0) len = 1;
         else if (length_reg > WIN_MAX) len = WIN_MAX;
         else len = length_reg;

         if (wr_ptr >= len) wr_ptr = 0;
         window[wr_ptr] = sample;
         wr_ptr++;
         if (wr_ptr >= len) wr_ptr = 0;
         if (fill < len) fill++;

         for (a = 0; a < fill; a++) begin
            key = window[a];
            b = a;
            while (b > 0 && sorted[b-1] > key) begin
               sorted[b] = sorted[b-1];
               b--;
            end
            sorted[b] = key;
         end

         if (fill % 2 == 1) begin
            median = sorted[fill/2];
         end else begin
            // The 17-bit sum cannot overflow; dropping its low bit floors it.
            sum    = sorted[fill/2-1] + sorted[fill/2];
            median = sum[16:1];
         end
         expected_medians.push_back(median);
      endfunction

      function void check_median(logic signed [15:0] got);
         logic signed [15:0] want;

         if (expected_medians.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("median result %0d arrived with nothing expected", got);
            return;
         end
         want = expected_medians.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("median mismatch: expected %0d, got %0d", want, got);
         end
      endfunction

      function int pending();
         return expected_medians.size();
      endfunction
   endclass

endpackage

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the sliding window median filter
// Drives short directed sequences of extreme samples, then phases of random
// samples under several window lengths (including the clamped ones), with
// bursty input and patterned output stall, and checks every median.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import median_check_pkg::*;

   localparam int WINDOW_MAX    = 8;
   localparam int SAMPLE_WIDTH  = 16;
   // This margin covers the slowest result with room.
   localparam int SETTLE_CYCLES = 32;
   localparam int IDLE_LIMIT    = 4000;
   localparam int RANDOM_ITEMS  = 1950;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC
   } stall_mode_type;

   typedef enum logic [1:0] {
      SMP_FULL,
      SMP_EXTREME,
      SMP_NEAR,
      SMP_REPEAT
   } sample_kind_type;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_sample  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall   = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_median;
   logic                           csr_wr_en   = 1'b0;
   logic [smf_pkg::LEN_W-1:0]      csr_wr_data = '0;

   median_scoreboard sb = new();

   sliding_median_filter_top #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_median  (rsp_median),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one item and hold it until the filter takes it. Valid is left
   // high afterwards, so the next item can follow back to back; only a gap
   // or a pause lowers it.
   task automatic send_sample(input logic signed [15:0] sample);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (req_stall);
      sb.note_sample(sample);
   endtask

   task automatic idle_for(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stop offering items until every expected median has come back, then
   // let the filter settle so that it is certainly idle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The register takes the value at the rising edge on which the write enable
   // is high, and the window restarts there, in the filter and in the
   // scoreboard alike.
   task automatic write_length(input logic [3:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      sb.write_length(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // The result side stalls in modes that last a random while: never, at
   // random, or periodically, three quarters of the time.
   stall_mode_type stall_mode  = STALL_NONE;
   int unsigned    mode_left   = 0;
   int unsigned    stall_phase = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode  <= stall_mode_type'($urandom_range(0, 2));
            mode_left   <= $urandom_range(20, 200);
         end else begin
            mode_left   <= mode_left - 1;
         end
         stall_phase <= stall_phase + 1;
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: rsp_stall <= (stall_phase % 4 != 0);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // Every median taken by the testbench is checked against the oldest one
   // still expected.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_median(rsp_median);
   end

   // The watchdog ends a run that stops moving: it counts cycles in which
   // neither channel hands over an item.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic signed [15:0] dir_default [] = '{
         16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1,
         16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8001, 16'sh8000
      };
      logic signed [15:0] dir_short [] = '{16'sh8000, 16'sh7FFF, 16'sh5555, 16'shAAAA};
      logic signed [15:0] dir_long  [] = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000};
      logic signed [15:0] dir_pair  [] = '{16'sh8000, 16'sh8001, -16'sd3};
      logic [3:0]         first_lengths [] = '{
         4'd1, 4'd0, 4'd15, 4'd9, 4'd2, 4'd8, 4'd3, 4'd5, 4'd7, 4'd4, 4'd6
      };
      int unsigned        sent;
      int unsigned        phase;
      int unsigned        phase_items;
      int unsigned        burst_left;
      bit                 no_gaps;
      logic signed [15:0] sample;
      logic signed [15:0] last_sample;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Under the reset length the window fills to eight and
      // then wraps; the even counts include sums of the most negative and the
      // most positive samples, which must floor and must not overflow.
      foreach (dir_default[k]) send_sample(dir_default[k]);
      drain();
      // A length of zero behaves as one, so each median is the sample itself.
      write_length(4'd0);
      foreach (dir_short[k]) send_sample(dir_short[k]);
      drain();
      // A length beyond the maximum is clamped to eight.
      write_length(4'd15);
      foreach (dir_long[k]) send_sample(dir_long[k]);
      drain();
      // A two-entry window: the mean of two negative extremes rounds down.
      write_length(4'd2);
      foreach (dir_pair[k]) send_sample(dir_pair[k]);
      drain();

      // Random part, in phases of one window length each. Every phase ends
      // with a full drain, which is also the pause of the sender.
      sent        = 0;
      phase       = 0;
      last_sample = '0;
      while (sent < RANDOM_ITEMS) begin
         if (phase < first_lengths.size()) write_length(first_lengths[phase]);
         else write_length(4'($urandom_range(0, 15)));
         phase++;
         phase_items = $urandom_range(80, 200);
         // The last phase stops at the planned number of items.
         if (phase_items > RANDOM_ITEMS - sent) phase_items = RANDOM_ITEMS - sent;
         no_gaps     = ($urandom_range(0, 3) == 0);
         burst_left  = 0;
         for (int i = 0; i < phase_items; i++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if (!no_gaps) idle_for($urandom_range(1, 8));
            end
            burst_left--;
            // Close values and repeats give ties and equal middle pairs;
            // extremes exercise the rounding of the mean at both ends.
            case (sample_kind_type'($urandom_range(0, 3)))
               SMP_EXTREME: sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               SMP_NEAR:    sample = 16'(int'($urandom_range(0, 8)) - 4);
               SMP_REPEAT:  sample = last_sample;
               default:     sample = 16'($urandom);
            endcase
            last_sample = sample;
            send_sample(sample);
            sent++;
         end
         drain();
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
